FILE: src/bilinear_texel_blend_unit_defines.svh
// Assertion macros for the bilinear texel blend unit checker.
// Holds no logic; included by the checker file only.
`ifndef BILINEAR_TEXEL_BLEND_UNIT_DEFINES_SVH
`define BILINEAR_TEXEL_BLEND_UNIT_DEFINES_SVH

// Delayed implication: the consequent must hold after the antecedent.
`define BTB_ASSERT_AFTER3(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##3 (cons)) \
		else $error("%m: check failed three cycles after trigger");

// Consequent must hold in the same cycle as the antecedent.
`define BTB_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

`endif

FILE: src/btb_pkg.sv
// Shared types and constants for the bilinear texel blend unit.
// No dependencies; imported by every module of the block.
package btb_pkg;

	localparam int FRAC_BITS_DEF = 4;
	localparam int CHAN_W        = 8;
	localparam int TEXEL_W       = 32;
	localparam int FRAC_W        = 4;
	localparam int PIXEL_W       = 24;
	localparam int LANES         = 4;

	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
	} rgb_t;

endpackage

FILE: src/btb_lane.sv
// One blend lane: scales the three channels of a texel by its weight.
// Depends on btb_pkg; outputs are registered.
module btb_lane #(
	parameter int FRAC_BITS = btb_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  btb_pkg::rgb_t                     texel,
	input  logic [2*FRAC_BITS:0]              weight,
	output logic [btb_pkg::CHAN_W+2*FRAC_BITS:0] red_prod_s2,
	output logic [btb_pkg::CHAN_W+2*FRAC_BITS:0] green_prod_s2,
	output logic [btb_pkg::CHAN_W-1:0]        blue_part_s2
);
	import btb_pkg::*;

	localparam int WW = 2*FRAC_BITS + 1;
	localparam int PW = CHAN_W + WW;

	logic [PW-1:0] blue_prod;

	assign blue_prod = PW'(texel.b) * PW'(weight);

	always_ff @(posedge clk) begin
		red_prod_s2   <= PW'(texel.r) * PW'(weight);
		green_prod_s2 <= PW'(texel.g) * PW'(weight);
		blue_part_s2  <= CHAN_W'(blue_prod >> (2*FRAC_BITS));
	end

endmodule

FILE: src/btb_merge.sv
// Merge stage: sums the four lane products and packs the output pixel.
// Depends on btb_pkg; output is registered.
module btb_merge #(
	parameter int FRAC_BITS = btb_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic [btb_pkg::CHAN_W+2*FRAC_BITS:0]  red_prod [btb_pkg::LANES],
	input  logic [btb_pkg::CHAN_W+2*FRAC_BITS:0]  green_prod [btb_pkg::LANES],
	input  logic [btb_pkg::CHAN_W-1:0]            blue_part [btb_pkg::LANES],
	output btb_pkg::rgb_t                         pixel_s3
);
	import btb_pkg::*;

	localparam int PW = CHAN_W + 2*FRAC_BITS + 1;
	localparam int SW = PW + 2;
	localparam int BW = CHAN_W + 2;

	logic [SW-1:0] red_sum;
	logic [SW-1:0] green_sum;
	logic [BW-1:0] blue_sum;

	always_comb begin
		red_sum   = '0;
		green_sum = '0;
		blue_sum  = '0;
		for (int i = 0; i < LANES; i++) begin
			red_sum   = red_sum + SW'(red_prod[i]);
			green_sum = green_sum + SW'(green_prod[i]);
			blue_sum  = blue_sum + BW'(blue_part[i]);
		end
	end

	always_ff @(posedge clk) begin
		pixel_s3.r <= CHAN_W'(red_sum >> (2*FRAC_BITS));
		pixel_s3.g <= CHAN_W'(green_sum >> (2*FRAC_BITS));
		pixel_s3.b <= CHAN_W'(blue_sum);
	end

endmodule

FILE: src/bilinear_texel_blend_unit.sv
// Bilinear texel blend unit: start passes through valid_s1, valid_s2 and valid_s3 to done.
// Throughput is one transaction per clock; busy stays low, since the four
// multiply lanes and the merge stage are fully pipelined and never stall.
// Reset clears only the valid pipeline; payload registers are not reset.
// Depends on btb_pkg, btb_lane and btb_merge.
module bilinear_texel_blend_unit #(
	parameter int FRAC_BITS = btb_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [btb_pkg::TEXEL_W-1:0]   texel_base,
	input  logic [btb_pkg::TEXEL_W-1:0]   texel_right,
	input  logic [btb_pkg::TEXEL_W-1:0]   texel_below,
	input  logic [btb_pkg::TEXEL_W-1:0]   texel_diagonal,
	input  logic [btb_pkg::FRAC_W-1:0]    frac_u,
	input  logic [btb_pkg::FRAC_W-1:0]    frac_v,
	output logic                          done,
	output logic [btb_pkg::PIXEL_W-1:0]   pixel_color
);
	import btb_pkg::*;

	localparam int FW = FRAC_BITS;
	localparam int WW = 2*FW + 1;
	localparam int PW = CHAN_W + WW;
	localparam logic [FW:0] ONE = (FW+1)'(1) << FW;

	logic [FW-1:0] u;
	logic [FW-1:0] v;
	logic [FW:0]   one_m_u;
	logic [FW:0]   one_m_v;
	logic [WW-1:0] weight_d [LANES];
	logic [WW-1:0] weight_s1 [LANES];
	rgb_t          texel_s1 [LANES];
	logic [PW-1:0] red_prod_s2 [LANES];
	logic [PW-1:0] green_prod_s2 [LANES];
	logic [CHAN_W-1:0] blue_part_s2 [LANES];
	rgb_t          pixel_s3;
	logic          valid_s1;
	logic          valid_s2;
	logic          valid_s3;

	assign u       = FW'(frac_u);
	assign v       = FW'(frac_v);
	assign one_m_u = ONE - {1'b0, u};
	assign one_m_v = ONE - {1'b0, v};

	assign weight_d[0] = WW'(one_m_u) * WW'(one_m_v);
	assign weight_d[1] = WW'(u) * WW'(one_m_v);
	assign weight_d[2] = WW'(one_m_u) * WW'(v);
	assign weight_d[3] = WW'(u) * WW'(v);

	always_ff @(posedge clk) begin
		texel_s1[0] <= texel_base[PIXEL_W-1:0];
		texel_s1[1] <= texel_right[PIXEL_W-1:0];
		texel_s1[2] <= texel_below[PIXEL_W-1:0];
		texel_s1[3] <= texel_diagonal[PIXEL_W-1:0];
		weight_s1   <= weight_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		btb_lane #(
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk          (clk),
			.texel        (texel_s1[i]),
			.weight       (weight_s1[i]),
			.red_prod_s2  (red_prod_s2[i]),
			.green_prod_s2(green_prod_s2[i]),
			.blue_part_s2 (blue_part_s2[i])
		);
	end

	btb_merge #(
		.FRAC_BITS(FRAC_BITS)
	) u_merge (
		.clk       (clk),
		.red_prod  (red_prod_s2),
		.green_prod(green_prod_s2),
		.blue_part (blue_part_s2),
		.pixel_s3  (pixel_s3)
	);

	assign busy        = 1'b0;
	assign done        = valid_s3;
	assign pixel_color = pixel_s3;

endmodule

FILE: src/btb_checker.sv
// Port-level checker for the bilinear texel blend unit, bound to the top level.
// Depends on btb_pkg and bilinear_texel_blend_unit_defines.svh.
`include "bilinear_texel_blend_unit_defines.svh"

module btb_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [btb_pkg::TEXEL_W-1:0]   texel_base,
	input logic [btb_pkg::FRAC_W-1:0]    frac_u,
	input logic [btb_pkg::FRAC_W-1:0]    frac_v,
	input logic                          done,
	input logic [btb_pkg::PIXEL_W-1:0]   pixel_color
);
	import btb_pkg::*;

	`BTB_ASSERT_AFTER3(a_start_gives_done, clk, arst_n, start && !busy, done)
	`BTB_ASSERT_IMPL(a_done_has_start, clk, arst_n, done, $past(start, 3))
	`BTB_ASSERT_AFTER3(a_zero_frac_is_base, clk, arst_n,
		start && !busy && frac_u == '0 && frac_v == '0,
		pixel_color == $past(texel_base[PIXEL_W-1:0], 3))

endmodule

bind bilinear_texel_blend_unit btb_checker u_btb_checker (.*);

FILE: tb/bilinear_texel_blend_unit_tb.sv
// Self-checking testbench for the bilinear texel blend unit: directed table, then random texels.
// Each pixel is compared with its table value or with an in-bench model of the four-texel weighted blend.
// Depends on btb_pkg and bilinear_texel_blend_unit.
module bilinear_texel_blend_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import btb_pkg::*;

	typedef struct packed {
		logic [TEXEL_W-1:0] base;
		logic [TEXEL_W-1:0] right;
		logic [TEXEL_W-1:0] below;
		logic [TEXEL_W-1:0] diagonal;
		logic [FRAC_W-1:0]  u;
		logic [FRAC_W-1:0]  v;
	} blend_job_t;

	typedef struct packed {
		blend_job_t         job;
		logic               known;
		logic [PIXEL_W-1:0] pixel;
	} table_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [TEXEL_W-1:0] texel_base;
	logic [TEXEL_W-1:0] texel_right;
	logic [TEXEL_W-1:0] texel_below;
	logic [TEXEL_W-1:0] texel_diagonal;
	logic [FRAC_W-1:0]  frac_u;
	logic [FRAC_W-1:0]  frac_v;
	logic               done;
	logic [PIXEL_W-1:0] pixel_color;

	logic [PIXEL_W-1:0] pending_pixels[$];
	table_row_t         blend_table[$];
	int                 jobs_sent;
	int                 pixels_seen;
	int                 mismatches;

	bilinear_texel_blend_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.texel_base(texel_base),
		.texel_right(texel_right),
		.texel_below(texel_below),
		.texel_diagonal(texel_diagonal),
		.frac_u(frac_u),
		.frac_v(frac_v),
		.done(done),
		.pixel_color(pixel_color)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("%0t: timeout", $time);
		$display("[bilinear_texel_blend_unit] ERROR");
		$finish;
	end

	function automatic logic [PIXEL_W-1:0] blend_pixel(blend_job_t j);
		int unsigned        scale;
		int unsigned        shift;
		int unsigned        fu;
		int unsigned        fv;
		int unsigned        w[LANES];
		logic [TEXEL_W-1:0] t[LANES];
		int unsigned        red;
		int unsigned        green;
		int unsigned        blue;
		scale = 1 << FRAC_BITS_DEF;
		shift = 2 * FRAC_BITS_DEF;
		fu = j.u & (scale - 1);
		fv = j.v & (scale - 1);
		w[0] = (scale - fu) * (scale - fv);
		w[1] = fu * (scale - fv);
		w[2] = (scale - fu) * fv;
		w[3] = scale * scale - w[0] - w[1] - w[2];
		t[0] = j.base;
		t[1] = j.right;
		t[2] = j.below;
		t[3] = j.diagonal;
		red = 0;
		green = 0;
		blue = 0;
		for (int i = 0; i < LANES; i++) begin
			red += t[i][23:16] * w[i];
			green += t[i][15:8] * w[i];
			blue += (t[i][7:0] * w[i]) >> shift;
		end
		red = red >> shift;
		green = green >> shift;
		return {red[7:0], green[7:0], blue[7:0]};
	endfunction

	function automatic logic [TEXEL_W-1:0] random_texel();
		case ($urandom_range(0, 9))
			0: return '1;
			1: return '0;
			2: return {8'($urandom_range(0, 255)), 8'hFF, 8'hFF, 8'hFF};
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [FRAC_W-1:0] random_frac();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return FRAC_W'($urandom_range(0, 15));
		endcase
	endfunction

	task automatic add_row(input logic [TEXEL_W-1:0] b, r, d, g, input logic [FRAC_W-1:0] u, v,
		input logic known, input logic [PIXEL_W-1:0] pixel);
		table_row_t row;
		row.job = '{base: b, right: r, below: d, diagonal: g, u: u, v: v};
		row.known = known;
		row.pixel = pixel;
		blend_table.push_back(row);
	endtask

	task automatic send_job(input blend_job_t j, input int idle_pct, input logic known,
		input logic [PIXEL_W-1:0] pixel);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
		start <= 1'b1;
		texel_base <= j.base;
		texel_right <= j.right;
		texel_below <= j.below;
		texel_diagonal <= j.diagonal;
		frac_u <= j.u;
		frac_v <= j.v;
		do @(posedge clk); while (busy);
		pending_pixels.push_back(known ? pixel : blend_pixel(j));
		jobs_sent++;
	endtask

	task automatic drain_pixels(input int limit);
		int cycles;
		cycles = 0;
		start <= 1'b0;
		while (pending_pixels.size() != 0 && cycles < limit) begin
			@(posedge clk);
			cycles++;
		end
	endtask

	always @(posedge clk) begin : pixel_check
		logic [PIXEL_W-1:0] want;
		if (arst_n && done) begin
			pixels_seen++;
			if (pending_pixels.size() == 0) begin
				$display("%0t: pixel_color %06h arrived with no transaction outstanding",
					$time, pixel_color);
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				if (pixel_color !== want) begin
					$display("%0t: pixel_color mismatch, expected %06h, actual %06h",
						$time, want, pixel_color);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		blend_job_t job;
		int         idle_pct[3];
		idle_pct = '{31, 58, 0};
		jobs_sent = 0;
		pixels_seen = 0;
		mismatches = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		texel_base <= '0;
		texel_right <= '0;
		texel_below <= '0;
		texel_diagonal <= '0;
		frac_u <= '0;
		frac_v <= '0;

		add_row(32'h0, 32'h0, 32'h0, 32'h0, 4'd0, 4'd0, 1'b1, 24'h000000);
		add_row('1, '1, '1, '1, 4'd0, 4'd0, 1'b1, 24'hFFFFFF);
		add_row(32'hFF123456, 32'h00FEDCBA, 32'h12345678, 32'h9ABCDEF0, 4'd0, 4'd0,
			1'b1, 24'h123456);
		add_row(32'h00ABCDEF, '1, '1, '1, 4'd0, 4'd0, 1'b1, 24'hABCDEF);
		add_row(32'hAAAAAAAA, 32'h55555555, 32'h55555555, 32'hAAAAAAAA, 4'd0, 4'd0,
			1'b1, 24'hAAAAAA);
		add_row(32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555, 4'd0, 4'd0,
			1'b1, 24'h555555);
		add_row(32'hFF000000, 32'hFF000000, 32'hFF000000, 32'hFF000000, 4'd7, 4'd9,
			1'b1, 24'h000000);
		add_row('1, '1, '1, '1, 4'd15, 4'd15, 1'b0, '0);
		add_row('1, '1, '1, '1, 4'd8, 4'd8, 1'b0, '0);
		add_row(32'h0, 32'h00FFFFFF, 32'h0, 32'h00FFFFFF, 4'd15, 4'd0, 1'b0, '0);
		add_row(32'h0, 32'h0, 32'h00FFFFFF, 32'h00FFFFFF, 4'd0, 4'd15, 1'b0, '0);
		add_row(32'h0, 32'h0, 32'h0, '1, 4'd15, 4'd15, 1'b0, '0);
		add_row(32'h00FF0000, 32'h0000FF00, 32'h000000FF, 32'h00808080, 4'd5, 4'd11, 1'b0, '0);
		add_row(32'h00102030, 32'h00405060, 32'h00708090, 32'h00A0B0C0, 4'd0, 4'd15, 1'b0, '0);
		add_row(32'h00FFFFFF, 32'h0, 32'h0, 32'h0, 4'd1, 4'd1, 1'b0, '0);
		add_row(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 4'd10, 4'd5, 1'b0, '0);
		add_row(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 4'd5, 4'd10, 1'b0, '0);
		add_row(32'h00FFFFFF, 32'h0, 32'h0, 32'h0, 4'd1, 4'd0, 1'b0, '0);
		add_row(32'h0, 32'h0, 32'h0, 32'h00010101, 4'd15, 4'd15, 1'b0, '0);
		add_row(32'h00FEFEFE, 32'h00FEFEFE, 32'h00FEFEFE, 32'h00FEFEFE, 4'd3, 4'd12, 1'b0, '0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (blend_table[i])
			send_job(blend_table[i].job, 0, blend_table[i].known, blend_table[i].pixel);
		drain_pixels(1000);

		for (int phase = 0; phase < 3; phase++) begin
			for (int n = 0; n < 460; n++) begin
				job.base = random_texel();
				job.right = random_texel();
				job.below = random_texel();
				job.diagonal = random_texel();
				job.u = random_frac();
				job.v = random_frac();
				send_job(job, idle_pct[phase], 1'b0, '0);
				if (n == 230)
					drain_pixels(1000);
			end
			drain_pixels(1000);
		end

		repeat (8) @(posedge clk);
		if (pending_pixels.size() != 0) begin
			$display("%0t: %0d expected pixels never arrived", $time, pending_pixels.size());
			mismatches += pending_pixels.size();
		end
		$display("Sent %0d blend transactions (corner table plus three idle mixes),",
			jobs_sent);
		$display("checked %0d pixels.", pixels_seen);
		$display("Mismatches found: %0d", mismatches);
		if (mismatches == 0)
			$display("[bilinear_texel_blend_unit] OK");
		else
			$display("[bilinear_texel_blend_unit] ERROR");
		$finish;
	end
endmodule
